// ===== sv/tmp_pkg.sv =====
`default_nettype none

package tmp_pkg;

    // Fixed widths of the result fields and of the limits.
    localparam int ACC_W = 33;
    localparam int VEL_W = 33;
    localparam int POS_W = 48;
    localparam int LIM_W = 32;
    // Width of the saturated acceleration denominator.
    localparam int DEN_W = 64;

    // Run state of the profile.
    typedef enum logic [3:0] {
        PP_IDLE   = 4'b0001,
        PP_ACCEL  = 4'b0010,
        PP_CRUISE = 4'b0100,
        PP_DECEL  = 4'b1000
    } prof_t;

    // Phase code carried by a result word.
    typedef enum logic [1:0] {
        OUT_ACCEL  = 2'd0,
        OUT_CRUISE = 2'd1,
        OUT_DECEL  = 2'd2
    } out_phase_t;

    // Status of the head of the command queue.
    typedef struct packed {
        logic valid;
        logic tick;
    } cmd_ctl_t;

    // One result word.
    typedef struct packed {
        logic signed [ACC_W-1:0] step_accel;
        logic signed [VEL_W-1:0] velocity;
        logic signed [POS_W-1:0] position;
        out_phase_t              phase;
        logic                    last;
    } res_t;

endpackage

`default_nettype wire

// ===== sv/tmp_front.sv =====
`default_nettype none

module tmp_front #(
    parameter int FRAC_BITS = 16,
    parameter int DIST_BITS = 32
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               push,
    output      logic                               full,
    input  wire logic                               action,
    input  wire logic signed [DIST_BITS-1:0]        distance,
    input  wire logic [tmp_pkg::LIM_W-1:0]          speed_limit,
    input  wire logic [tmp_pkg::LIM_W-1:0]          accel_limit,
    output      tmp_pkg::cmd_ctl_t                  cmd_ctl,
    output      logic                               cmd_neg,
    output      logic [((DIST_BITS+FRAC_BITS > 32) ? DIST_BITS+FRAC_BITS : 32)-1:0] cmd_dist,
    output      logic [tmp_pkg::LIM_W-1:0]          cmd_speed,
    output      logic [tmp_pkg::LIM_W-1:0]          cmd_accel,
    input  wire logic                               cmd_take
);

    localparam int DW    = DIST_BITS + FRAC_BITS;
    localparam int QW    = (DW > 32) ? DW : 32;
    localparam int DEPTH = 4;
    localparam int PW    = 2;
    localparam int CW    = 3;

    logic [DIST_BITS-1:0]      raw;
    logic [DIST_BITS-1:0]      mag;
    logic                      keep;
    logic                      wr_en;
    logic                      rd_en;

    logic                      q_tick_reg  [DEPTH];
    logic                      q_neg_reg   [DEPTH];
    logic [QW-1:0]             q_dist_reg  [DEPTH];
    logic [tmp_pkg::LIM_W-1:0] q_speed_reg [DEPTH];
    logic [tmp_pkg::LIM_W-1:0] q_accel_reg [DEPTH];

    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    // A start with nothing to move is dropped here; it could never produce a sample.
    assign raw   = distance;
    assign mag   = raw[DIST_BITS-1] ? (~raw + 1'b1) : raw;
    assign keep  = action | ((|raw) & (|speed_limit) & (|accel_limit));
    assign full  = (cnt_reg == CW'(DEPTH));
    assign wr_en = push & ~full & keep;
    assign rd_en = cmd_take & (cnt_reg != '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PW'(wr_en);
        rd_ptr_next = rd_ptr_reg + PW'(rd_en);
        cnt_next    = cnt_reg + CW'(wr_en) - CW'(rd_en);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            q_tick_reg[wr_ptr_reg]  <= action;
            q_neg_reg[wr_ptr_reg]   <= raw[DIST_BITS-1];
            q_dist_reg[wr_ptr_reg]  <= QW'({mag, {FRAC_BITS{1'b0}}});
            q_speed_reg[wr_ptr_reg] <= speed_limit;
            q_accel_reg[wr_ptr_reg] <= accel_limit;
        end
    end

    assign cmd_ctl.valid = (cnt_reg != '0);
    assign cmd_ctl.tick  = q_tick_reg[rd_ptr_reg];
    assign cmd_neg       = q_neg_reg[rd_ptr_reg];
    assign cmd_dist      = q_dist_reg[rd_ptr_reg];
    assign cmd_speed     = q_speed_reg[rd_ptr_reg];
    assign cmd_accel     = q_accel_reg[rd_ptr_reg];

endmodule

`default_nettype wire

// ===== sv/tmp_div.sv =====
`default_nettype none

module tmp_div #(
    parameter int NW = 48,
    parameter int VW = 64
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [NW-1:0] dividend,
    input  wire logic [VW-1:0] divisor,
    output      logic          done,
    output      logic [NW-1:0] quot,
    output      logic [VW-1:0] rem
);

    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] quot_reg;
    logic [VW-1:0] rem_reg;
    logic [VW-1:0] dvs_reg;
    logic [CW-1:0] cnt_reg;
    logic          done_reg;
    logic [VW:0]   trial;
    logic [VW:0]   diff;
    logic          ge;

    // Restoring division, one quotient bit per cycle.
    assign trial = {rem_reg, quot_reg[NW-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign ge    = (trial >= {1'b0, dvs_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == CW'(1)) && !start;
            if (start)
                cnt_reg <= CW'(NW);
            else if (cnt_reg != '0)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= dividend;
            rem_reg  <= '0;
            dvs_reg  <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            quot_reg <= {quot_reg[NW-2:0], ge};
            rem_reg  <= ge ? diff[VW-1:0] : trial[VW-1:0];
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;
    assign rem  = rem_reg;

endmodule

`default_nettype wire

// ===== sv/tmp_sqrt.sv =====
`default_nettype none

module tmp_sqrt #(
    parameter int TW = 24
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire logic [2*TW-1:0] radicand,
    output      logic            done,
    output      logic [TW-1:0]   root,
    output      logic            exact
);

    localparam int XW = 2 * TW;
    localparam int CW = $clog2(TW + 1);

    logic [XW-1:0] rem_reg;
    logic [XW-1:0] root_reg;
    logic [XW-1:0] one_reg;
    logic [CW-1:0] cnt_reg;
    logic          done_reg;
    logic [XW:0]   sum;
    logic          ge;

    // Digit-by-digit square root, one result bit per cycle.
    assign sum = {1'b0, root_reg} + {1'b0, one_reg};
    assign ge  = ({1'b0, rem_reg} >= sum);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == CW'(1)) && !start;
            if (start)
                cnt_reg <= CW'(TW);
            else if (cnt_reg != '0)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= radicand;
            root_reg <= '0;
            one_reg  <= XW'(1) << (XW - 2);
        end
        else if (cnt_reg != '0)
        begin
            if (ge)
            begin
                rem_reg  <= rem_reg - sum[XW-1:0];
                root_reg <= (root_reg >> 1) + one_reg;
            end
            else
            begin
                root_reg <= root_reg >> 1;
            end
            one_reg <= one_reg >> 2;
        end
    end

    assign done  = done_reg;
    assign root  = root_reg[TW-1:0];
    assign exact = (rem_reg == '0);

endmodule

`default_nettype wire

// ===== sv/tmp_back.sv =====
`default_nettype none

module tmp_back #(
    parameter int FRAC_BITS = 16,
    parameter int DIST_BITS = 32
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire tmp_pkg::cmd_ctl_t         cmd_ctl,
    input  wire logic                      cmd_neg,
    input  wire logic [((DIST_BITS+FRAC_BITS > 32) ? DIST_BITS+FRAC_BITS : 32)-1:0] cmd_dist,
    input  wire logic [tmp_pkg::LIM_W-1:0] cmd_speed,
    input  wire logic [tmp_pkg::LIM_W-1:0] cmd_accel,
    output      logic                      cmd_take,
    output      logic                      res_empty,
    output      tmp_pkg::res_t             res_word,
    input  wire logic                      res_pop
);

    localparam int DW    = DIST_BITS + FRAC_BITS;
    localparam int QW    = (DW > 32) ? DW : 32;
    localparam int TW    = (DW + 1) / 2;
    localparam int XW    = 2 * TW;
    localparam int MCW   = (tmp_pkg::LIM_W + TW > QW + 1) ? tmp_pkg::LIM_W + TW : QW + 1;
    localparam int PRW0  = MCW + TW;
    localparam int PRW   = (PRW0 > tmp_pkg::DEN_W) ? PRW0 : tmp_pkg::DEN_W + 1;
    localparam int MCNTW = $clog2(TW + 1);
    localparam int AW    = tmp_pkg::ACC_W;
    localparam int VW    = tmp_pkg::VEL_W;
    localparam int PSW   = tmp_pkg::POS_W;
    localparam int LW    = tmp_pkg::LIM_W;
    localparam int NW    = tmp_pkg::DEN_W;

    typedef enum logic [8:0] {
        SQ_WAIT    = 9'b000000001,
        SQ_DIV_DA  = 9'b000000010,
        SQ_SQRT    = 9'b000000100,
        SQ_DIV_VA  = 9'b000001000,
        SQ_MUL_AT  = 9'b000010000,
        SQ_MUL_ATT = 9'b000100000,
        SQ_DIV_LV  = 9'b001000000,
        SQ_MUL_DEN = 9'b010000000,
        SQ_DIV_QA  = 9'b100000000
    } seq_t;

    seq_t            seq_reg, seq_next;
    tmp_pkg::prof_t  prof_reg, prof_next;

    // Planning registers.
    logic            neg_reg, neg_next;
    logic [QW-1:0]   d_reg, d_next;
    logic [LW-1:0]   v_reg, v_next;
    logic [LW-1:0]   a_reg, a_next;
    logic [TW-1:0]   t1_reg, t1_next;
    logic [TW-1:0]   tn_reg, tn_next;
    logic [QW-1:0]   t2_reg, t2_next;
    logic [NW-1:0]   den_reg, den_next;

    // Shift-add multiplier.
    logic [PRW-1:0]   mul_acc_reg;
    logic [PRW-1:0]   mul_mc_reg;
    logic [TW-1:0]    mul_mp_reg;
    logic [MCNTW-1:0] mul_cnt_reg;
    logic             mul_start;
    logic [PRW-1:0]   mul_mc_in;
    logic [TW-1:0]    mul_mp_in;

    // Running profile.
    logic [QW-1:0]          tick_cnt_reg, tick_cnt_next;
    logic [TW-1:0]          accel_ticks_reg, accel_ticks_next;
    logic [QW-1:0]          cruise_ticks_reg, cruise_ticks_next;
    logic signed [AW-1:0]   planned_reg, planned_next;
    logic signed [VW-1:0]   vel_reg, vel_next;
    logic signed [PSW-1:0]  pos_reg, pos_next;

    // Shared divider and the square root unit.
    logic            div_start;
    logic [QW-1:0]   div_nd;
    logic [NW-1:0]   div_dv;
    logic            div_done;
    logic [QW-1:0]   div_q;
    logic [NW-1:0]   div_r;
    logic            div_inexact;
    logic            sq_start;
    logic [XW-1:0]   sq_x;
    logic            sq_done;
    logic [TW-1:0]   sq_root;
    logic            sq_exact;

    // Tick datapath.
    logic signed [AW-1:0]  acc_cur;
    logic signed [VW:0]    vsum;
    logic signed [VW-1:0]  vel_new;
    logic signed [PSW:0]   psum;
    logic signed [PSW-1:0] pos_new;
    logic [QW-1:0]         tick_inc;
    logic [QW-1:0]         tick_after;
    tmp_pkg::prof_t        prof_after;
    logic                  is_last;
    tmp_pkg::out_phase_t   phase_cur;

    // Planning temporaries.
    logic [QW-1:0]   ceil_q;
    logic [QW-1:0]   left;
    logic [NW-1:0]   den_sat;
    logic            round_up;
    logic [QW:0]     qa;
    logic [LW-1:0]   qa_sat;
    logic signed [AW-1:0] qa_ext;

    // Result queue.
    tmp_pkg::res_t res_q_reg [2];
    tmp_pkg::res_t res_in;
    logic          res_push;
    logic          res_full;
    logic          res_rd;
    logic          res_wr_ptr_reg;
    logic          res_rd_ptr_reg;
    logic [1:0]    res_cnt_reg;

    tmp_div #(
        .NW (QW),
        .VW (NW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_nd),
        .divisor  (div_dv),
        .done     (div_done),
        .quot     (div_q),
        .rem      (div_r)
    );

    tmp_sqrt #(
        .TW (TW)
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (sq_x),
        .done     (sq_done),
        .root     (sq_root),
        .exact    (sq_exact)
    );

    assign div_inexact = (div_r != '0);
    assign ceil_q      = div_q + QW'(div_inexact);
    assign left        = d_reg - mul_acc_reg[QW-1:0];
    assign den_sat     = (|mul_acc_reg[PRW-1:NW]) ? '1 : mul_acc_reg[NW-1:0];
    assign round_up    = ({div_r, 1'b0} >= {1'b0, den_reg});
    assign qa          = {1'b0, div_q} + (QW+1)'(round_up);
    assign qa_sat      = (|qa[QW:LW]) ? '1 : qa[LW-1:0];
    assign qa_ext      = $signed({1'b0, qa_sat});

    // Acceleration, velocity and position of the next sample.
    always_comb
    begin
        unique case (prof_reg)
            tmp_pkg::PP_ACCEL:
            begin
                acc_cur   = planned_reg;
                phase_cur = tmp_pkg::OUT_ACCEL;
            end
            tmp_pkg::PP_CRUISE:
            begin
                acc_cur   = '0;
                phase_cur = tmp_pkg::OUT_CRUISE;
            end
            tmp_pkg::PP_DECEL:
            begin
                acc_cur   = -planned_reg;
                phase_cur = tmp_pkg::OUT_DECEL;
            end
            default:
            begin
                acc_cur   = '0;
                phase_cur = tmp_pkg::OUT_ACCEL;
            end
        endcase
    end

    always_comb
    begin
        vsum = (VW+1)'(vel_reg) + (VW+1)'(acc_cur);
        if (vsum[VW:VW-1] == 2'b01)
            vel_new = $signed({1'b0, {(VW-1){1'b1}}});
        else if (vsum[VW:VW-1] == 2'b10)
            vel_new = $signed({1'b1, {(VW-1){1'b0}}});
        else
            vel_new = vsum[VW-1:0];

        psum = (PSW+1)'(pos_reg) + (PSW+1)'(vel_new);
        if (psum[PSW:PSW-1] == 2'b01)
            pos_new = $signed({1'b0, {(PSW-1){1'b1}}});
        else if (psum[PSW:PSW-1] == 2'b10)
            pos_new = $signed({1'b1, {(PSW-1){1'b0}}});
        else
            pos_new = psum[PSW-1:0];
    end

    always_comb
    begin
        tick_inc   = tick_cnt_reg + 1'b1;
        tick_after = tick_inc;
        prof_after = prof_reg;
        is_last    = 1'b0;
        unique case (prof_reg)
            tmp_pkg::PP_ACCEL:
            begin
                if (tick_inc >= QW'(accel_ticks_reg))
                begin
                    prof_after = (cruise_ticks_reg != '0) ? tmp_pkg::PP_CRUISE
                                                          : tmp_pkg::PP_DECEL;
                    tick_after = '0;
                end
            end
            tmp_pkg::PP_CRUISE:
            begin
                if (tick_inc >= cruise_ticks_reg)
                begin
                    prof_after = tmp_pkg::PP_DECEL;
                    tick_after = '0;
                end
            end
            tmp_pkg::PP_DECEL:
            begin
                if (tick_inc >= QW'(accel_ticks_reg))
                begin
                    prof_after = tmp_pkg::PP_IDLE;
                    tick_after = '0;
                    is_last    = 1'b1;
                end
            end
            default:
            begin
                tick_after = tick_cnt_reg;
            end
        endcase
    end

    assign res_in.step_accel = acc_cur;
    assign res_in.velocity   = vel_new;
    assign res_in.position   = pos_new;
    assign res_in.phase      = phase_cur;
    assign res_in.last       = is_last;

    // Command sequencer: a tick steps the profile from the wait state, a start walks the planning steps.
    always_comb
    begin
        seq_next          = seq_reg;
        prof_next         = prof_reg;
        neg_next          = neg_reg;
        d_next            = d_reg;
        v_next            = v_reg;
        a_next            = a_reg;
        t1_next           = t1_reg;
        tn_next           = tn_reg;
        t2_next           = t2_reg;
        den_next          = den_reg;
        tick_cnt_next     = tick_cnt_reg;
        accel_ticks_next  = accel_ticks_reg;
        cruise_ticks_next = cruise_ticks_reg;
        planned_next      = planned_reg;
        vel_next          = vel_reg;
        pos_next          = pos_reg;
        cmd_take          = 1'b0;
        res_push          = 1'b0;
        div_start         = 1'b0;
        div_nd            = d_reg;
        div_dv            = NW'(a_reg);
        sq_start          = 1'b0;
        sq_x              = XW'(ceil_q);
        mul_start         = 1'b0;
        mul_mc_in         = '0;
        mul_mp_in         = '0;

        unique case (seq_reg)
            SQ_WAIT:
            begin
                if (cmd_ctl.valid)
                begin
                    if (cmd_ctl.tick)
                    begin
                        if (prof_reg == tmp_pkg::PP_IDLE)
                        begin
                            cmd_take = 1'b1;
                        end
                        else if (!res_full)
                        begin
                            cmd_take      = 1'b1;
                            res_push      = 1'b1;
                            vel_next      = vel_new;
                            pos_next      = pos_new;
                            tick_cnt_next = tick_after;
                            prof_next     = prof_after;
                        end
                    end
                    else
                    begin
                        cmd_take = 1'b1;
                        // A start that arrives during a move is dropped.
                        if (prof_reg == tmp_pkg::PP_IDLE)
                        begin
                            neg_next  = cmd_neg;
                            d_next    = cmd_dist;
                            v_next    = cmd_speed;
                            a_next    = cmd_accel;
                            div_start = 1'b1;
                            div_nd    = cmd_dist;
                            div_dv    = NW'(cmd_accel);
                            seq_next  = SQ_DIV_DA;
                        end
                    end
                end
            end
            SQ_DIV_DA:
            begin
                if (div_done)
                begin
                    sq_start = 1'b1;
                    sq_x     = XW'(ceil_q);
                    seq_next = SQ_SQRT;
                end
            end
            SQ_SQRT:
            begin
                if (sq_done)
                begin
                    t1_next   = sq_root + TW'(!sq_exact);
                    div_start = 1'b1;
                    div_nd    = QW'(v_reg);
                    div_dv    = NW'(a_reg);
                    seq_next  = SQ_DIV_VA;
                end
            end
            SQ_DIV_VA:
            begin
                if (div_done)
                begin
                    mul_start = 1'b1;
                    if (QW'(t1_reg) > div_q)
                    begin
                        // The speed limit cuts the ramp short.
                        t1_next = TW'(ceil_q);
                        if (ceil_q < QW'(t1_reg))
                        begin
                            tn_next   = TW'(ceil_q);
                            mul_mc_in = PRW'(a_reg);
                            mul_mp_in = TW'(ceil_q);
                            seq_next  = SQ_MUL_AT;
                        end
                        else
                        begin
                            t2_next   = '0;
                            mul_mc_in = PRW'(ceil_q);
                            mul_mp_in = TW'(ceil_q);
                            seq_next  = SQ_MUL_DEN;
                        end
                    end
                    else
                    begin
                        t2_next   = '0;
                        mul_mc_in = PRW'(t1_reg);
                        mul_mp_in = t1_reg;
                        seq_next  = SQ_MUL_DEN;
                    end
                end
            end
            SQ_MUL_AT:
            begin
                if (mul_cnt_reg == '0)
                begin
                    mul_start = 1'b1;
                    mul_mc_in = mul_acc_reg;
                    mul_mp_in = tn_reg;
                    seq_next  = SQ_MUL_ATT;
                end
            end
            SQ_MUL_ATT:
            begin
                if (mul_cnt_reg == '0)
                begin
                    div_start = 1'b1;
                    div_nd    = left;
                    div_dv    = NW'(v_reg);
                    seq_next  = SQ_DIV_LV;
                end
            end
            SQ_DIV_LV:
            begin
                if (div_done)
                begin
                    t2_next   = ceil_q;
                    mul_start = 1'b1;
                    mul_mc_in = PRW'(ceil_q) + PRW'(t1_reg);
                    mul_mp_in = t1_reg;
                    seq_next  = SQ_MUL_DEN;
                end
            end
            SQ_MUL_DEN:
            begin
                if (mul_cnt_reg == '0)
                begin
                    den_next  = den_sat;
                    div_start = 1'b1;
                    div_nd    = d_reg;
                    div_dv    = den_sat;
                    seq_next  = SQ_DIV_QA;
                end
            end
            SQ_DIV_QA:
            begin
                if (div_done)
                begin
                    planned_next      = neg_reg ? -qa_ext : qa_ext;
                    accel_ticks_next  = t1_reg;
                    cruise_ticks_next = t2_reg;
                    tick_cnt_next     = '0;
                    vel_next          = '0;
                    pos_next          = '0;
                    prof_next         = tmp_pkg::PP_ACCEL;
                    seq_next          = SQ_WAIT;
                end
            end
            default:
            begin
                seq_next = SQ_WAIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg        <= SQ_WAIT;
            prof_reg       <= tmp_pkg::PP_IDLE;
            mul_cnt_reg    <= '0;
            res_wr_ptr_reg <= 1'b0;
            res_rd_ptr_reg <= 1'b0;
            res_cnt_reg    <= '0;
        end
        else
        begin
            seq_reg  <= seq_next;
            prof_reg <= prof_next;
            if (mul_start)
                mul_cnt_reg <= MCNTW'(TW);
            else if (mul_cnt_reg != '0)
                mul_cnt_reg <= mul_cnt_reg - 1'b1;
            res_wr_ptr_reg <= res_wr_ptr_reg ^ res_push;
            res_rd_ptr_reg <= res_rd_ptr_reg ^ res_rd;
            res_cnt_reg    <= res_cnt_reg + 2'(res_push) - 2'(res_rd);
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg          <= neg_next;
        d_reg            <= d_next;
        v_reg            <= v_next;
        a_reg            <= a_next;
        t1_reg           <= t1_next;
        tn_reg           <= tn_next;
        t2_reg           <= t2_next;
        den_reg          <= den_next;
        tick_cnt_reg     <= tick_cnt_next;
        accel_ticks_reg  <= accel_ticks_next;
        cruise_ticks_reg <= cruise_ticks_next;
        planned_reg      <= planned_next;
        vel_reg          <= vel_next;
        pos_reg          <= pos_next;
        if (mul_start)
        begin
            mul_acc_reg <= '0;
            mul_mc_reg  <= mul_mc_in;
            mul_mp_reg  <= mul_mp_in;
        end
        else if (mul_cnt_reg != '0)
        begin
            if (mul_mp_reg[0])
                mul_acc_reg <= mul_acc_reg + mul_mc_reg;
            mul_mc_reg <= mul_mc_reg << 1;
            mul_mp_reg <= mul_mp_reg >> 1;
        end
        if (res_push)
            res_q_reg[res_wr_ptr_reg] <= res_in;
    end

    assign res_full  = (res_cnt_reg == 2'd2);
    assign res_empty = (res_cnt_reg == 2'd0);
    assign res_rd    = res_pop & ~res_empty;
    assign res_word  = res_q_reg[res_rd_ptr_reg];

    a_res_count: assert property (@(posedge clk) disable iff (!rst_n)
        res_cnt_reg <= 2'd2)
        else $error("result queue count out of range");

    a_plan_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (seq_reg != SQ_WAIT) |-> (prof_reg == tmp_pkg::PP_IDLE))
        else $error("planning while a move runs");

    a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (seq_reg == SQ_DIV_DA || seq_reg == SQ_DIV_VA ||
                      seq_reg == SQ_DIV_LV || seq_reg == SQ_DIV_QA))
        else $error("divider finished outside a division step");

    a_sqrt_owner: assert property (@(posedge clk) disable iff (!rst_n)
        sq_done |-> (seq_reg == SQ_SQRT))
        else $error("square root finished outside its step");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && res_in.last) |=> (prof_reg == tmp_pkg::PP_IDLE))
        else $error("profile still running after its last sample");

endmodule

`default_nettype wire

// ===== sv/trapezoid_motion_profile.sv =====
// Trapezoidal motion profile generator.
// Input channel: a queue-style port (push/full). Each word is either a start
// (action low) carrying a signed distance and the speed and acceleration limits,
// or a tick (action high). Result channel: a queue-style port (empty/pop); each
// tick during a move yields one word with acceleration, velocity, position,
// phase and a flag on the final sample of the move.
// Commands sit in a four-word queue in front of the planning and stepping engine.
// A tick passes through the command queue and the result queue, both registered;
// ticks stream at one per cycle while results are taken and no start is planned.
// A start runs up to four serial divisions of QW-bit dividends, with
// QW = max(DIST_BITS+FRAC_BITS, 32), a square root and up to three shift-add
// multiplies by TW-bit multipliers, with TW = (DIST_BITS+FRAC_BITS+1)/2; the
// shared divider dominates. Ticks queued behind a start wait.
// A start during a move, and a start with zero distance, speed or acceleration,
// is dropped; a tick with no move running yields nothing.
// Reset empties both queues and leaves the generator idle.
// When the receiver stops popping, the two-word result queue fills, the engine
// holds the next tick, and the command queue then raises full.
`default_nettype none

module trapezoid_motion_profile #(
    parameter int FRAC_BITS = 16,
    parameter int DIST_BITS = 32
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              push,
    output      logic                              full,
    input  wire logic                              action,
    input  wire logic signed [DIST_BITS-1:0]       distance,
    input  wire logic [tmp_pkg::LIM_W-1:0]         speed_limit,
    input  wire logic [tmp_pkg::LIM_W-1:0]         accel_limit,
    output      logic                              empty,
    input  wire logic                              pop,
    output      logic signed [tmp_pkg::ACC_W-1:0]  step_accel,
    output      logic signed [tmp_pkg::VEL_W-1:0]  velocity,
    output      logic signed [tmp_pkg::POS_W-1:0]  position,
    output      logic [1:0]                        phase,
    output      logic                              last
);

    localparam int DW = DIST_BITS + FRAC_BITS;
    localparam int QW = (DW > 32) ? DW : 32;

    tmp_pkg::cmd_ctl_t         cmd_ctl;
    logic                      cmd_neg;
    logic [QW-1:0]             cmd_dist;
    logic [tmp_pkg::LIM_W-1:0] cmd_speed;
    logic [tmp_pkg::LIM_W-1:0] cmd_accel;
    logic                      cmd_take;
    tmp_pkg::res_t             res_word;

    // Front end: takes command words and screens out starts that cannot move.
    tmp_front #(
        .FRAC_BITS (FRAC_BITS),
        .DIST_BITS (DIST_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .action      (action),
        .distance    (distance),
        .speed_limit (speed_limit),
        .accel_limit (accel_limit),
        .cmd_ctl     (cmd_ctl),
        .cmd_neg     (cmd_neg),
        .cmd_dist    (cmd_dist),
        .cmd_speed   (cmd_speed),
        .cmd_accel   (cmd_accel),
        .cmd_take    (cmd_take)
    );

    // Back end: plans each move and steps the profile one tick at a time.
    tmp_back #(
        .FRAC_BITS (FRAC_BITS),
        .DIST_BITS (DIST_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_ctl   (cmd_ctl),
        .cmd_neg   (cmd_neg),
        .cmd_dist  (cmd_dist),
        .cmd_speed (cmd_speed),
        .cmd_accel (cmd_accel),
        .cmd_take  (cmd_take),
        .res_empty (empty),
        .res_word  (res_word),
        .res_pop   (pop)
    );

    assign step_accel = res_word.step_accel;
    assign velocity   = res_word.velocity;
    assign position   = res_word.position;
    assign phase      = res_word.phase;
    assign last       = res_word.last;

endmodule

`default_nettype wire

// ===== sim/tb_trapezoid_motion_profile.sv =====
`timescale 1ns / 1ps

module tb_trapezoid_motion_profile;

    localparam logic [63:0] MASK32 = 64'hFFFF_FFFF;
    localparam longint VEL_HI = 64'sd4294967295;
    localparam longint VEL_LO = -64'sd4294967296;
    localparam longint POS_HI = 64'sd140737488355327;
    localparam longint POS_LO = -64'sd140737488355328;
    // Number of ticks a random move may take, so that the run stays short.
    localparam int MOVE_TICKS_MAX = 80;
    // Wait budget for a start, which is planned in the engine and yields no word.
    localparam int START_CYCLES = 400;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic action = 1'b0;
    logic signed [31:0] distance = '0;
    logic [tmp_pkg::LIM_W-1:0] speed_limit = '0;
    logic [tmp_pkg::LIM_W-1:0] accel_limit = '0;
    logic pop = 1'b0;
    logic full;
    logic empty;
    logic signed [tmp_pkg::ACC_W-1:0] step_accel;
    logic signed [tmp_pkg::VEL_W-1:0] velocity;
    logic signed [tmp_pkg::POS_W-1:0] position;
    logic [1:0] phase;
    logic last;

    trapezoid_motion_profile dut (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .action(action),
        .distance(distance),
        .speed_limit(speed_limit),
        .accel_limit(accel_limit),
        .empty(empty),
        .pop(pop),
        .step_accel(step_accel),
        .velocity(velocity),
        .position(position),
        .phase(phase),
        .last(last)
    );

    // 12 ns clock period.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // The planned shape of one move, as the block should work it out at a start.
    typedef struct {
        logic        ok;
        longint      accel;
        logic [63:0] ramp_ticks;
        logic [63:0] cruise_ticks;
    } move_plan_t;

    // Our own copy of the profile state.
    tmp_pkg::prof_t run_state = tmp_pkg::PP_IDLE;
    logic [63:0]    tick_in_phase = '0;
    logic [63:0]    ramp_len = '0;
    logic [63:0]    cruise_len = '0;
    longint         move_accel = 0;
    longint         cur_velocity = 0;
    longint         cur_position = 0;

    // Samples still owed by the block, oldest first.
    tmp_pkg::res_t expected_samples[$];

    int err_cnt = 0;
    int words_sent = 0;
    int send_idle_pct = 0;
    int pop_stall_pct = 0;
    int pop_hold_cycles = 0;

    // Smallest r with r*r >= x, by the bitwise square root and a final round-up.
    function automatic logic [63:0] root_up(input logic [63:0] x);
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] b;
        rem = x;
        root = '0;
        b = 64'h4000_0000_0000_0000;
        while (b > rem)
            b = b >> 2;
        while (b != 0)
        begin
            if (rem >= root + b)
            begin
                rem = rem - (root + b);
                root = (root >> 1) + b;
            end
            else
                root = root >> 1;
            b = b >> 2;
        end
        if (root * root < x)
            root = root + 1;
        return root;
    endfunction

    function automatic logic [63:0] sat_sum(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction

    function automatic logic [63:0] sat_prod(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return (p[127:64] != 0) ? '1 : p[63:0];
    endfunction

    // Works out the phase lengths and the rescaled acceleration of a move.
    function automatic move_plan_t plan_move(input logic [31:0] move_len,
                                             input logic [31:0] spd,
                                             input logic [31:0] acc);
        move_plan_t  p;
        logic        neg;
        logic [63:0] mag;
        logic [63:0] d;
        logic [63:0] v;
        logic [63:0] a;
        logic [63:0] tn;
        logic [63:0] left;
        logic [63:0] den;
        logic [63:0] qa;
        logic [63:0] r;
        neg = move_len[31];
        mag = neg ? (64'h1_0000_0000 - {32'd0, move_len}) : {32'd0, move_len};
        d = mag << 16;
        v = {32'd0, spd};
        a = {32'd0, acc};
        p.ok = 1'b0;
        p.accel = 0;
        p.ramp_ticks = '0;
        p.cruise_ticks = '0;
        if (d == 0 || a == 0 || v == 0)
            return p;
        p.ramp_ticks = root_up(d / a + ((d % a) != 0));
        // The speed limit is reached first: shorten the ramp and cruise for the rest.
        if (p.ramp_ticks > v / a)
        begin
            tn = v / a + ((v % a) != 0);
            if (tn < p.ramp_ticks)
            begin
                left = d - a * tn * tn;
                p.cruise_ticks = left / v + ((left % v) != 0);
            end
            p.ramp_ticks = tn;
        end
        den = sat_prod(p.ramp_ticks, sat_sum(p.ramp_ticks, p.cruise_ticks));
        qa = d / den;
        r = d % den;
        if (r >= den - r)
            qa = qa + 1;
        if (qa > MASK32)
            qa = MASK32;
        p.accel = neg ? -longint'(qa) : longint'(qa);
        p.ramp_ticks = p.ramp_ticks & MASK32;
        p.ok = 1'b1;
        return p;
    endfunction

    function automatic longint clamp_to(input longint x, input longint lo, input longint hi);
        return (x < lo) ? lo : ((x > hi) ? hi : x);
    endfunction

    // Advances our copy of the profile by one accepted word and queues the
    // sample that it should produce, if any.
    task automatic predict_profile(input logic act, input logic [31:0] move_len,
                                   input logic [31:0] spd, input logic [31:0] acc);
        move_plan_t     p;
        longint         a_now;
        tmp_pkg::res_t  s;
        tmp_pkg::prof_t cur;
        logic           fin;
        if (!act)
        begin
            // A start during a move is dropped.
            if (run_state == tmp_pkg::PP_IDLE)
            begin
                p = plan_move(move_len, spd, acc);
                if (p.ok)
                begin
                    move_accel = p.accel;
                    ramp_len = p.ramp_ticks;
                    cruise_len = p.cruise_ticks;
                    tick_in_phase = '0;
                    cur_velocity = 0;
                    cur_position = 0;
                    run_state = tmp_pkg::PP_ACCEL;
                end
            end
            return;
        end
        if (run_state == tmp_pkg::PP_IDLE)
            return;
        cur = run_state;
        fin = 1'b0;
        a_now = (cur == tmp_pkg::PP_ACCEL) ? move_accel :
                ((cur == tmp_pkg::PP_CRUISE) ? 0 : -move_accel);
        cur_velocity = clamp_to(cur_velocity + a_now, VEL_LO, VEL_HI);
        cur_position = clamp_to(cur_position + cur_velocity, POS_LO, POS_HI);
        tick_in_phase = tick_in_phase + 1;
        if (cur == tmp_pkg::PP_ACCEL && tick_in_phase >= ramp_len)
        begin
            run_state = (cruise_len != 0) ? tmp_pkg::PP_CRUISE : tmp_pkg::PP_DECEL;
            tick_in_phase = '0;
        end
        else if (cur == tmp_pkg::PP_CRUISE && tick_in_phase >= cruise_len)
        begin
            run_state = tmp_pkg::PP_DECEL;
            tick_in_phase = '0;
        end
        else if (cur == tmp_pkg::PP_DECEL && tick_in_phase >= ramp_len)
        begin
            run_state = tmp_pkg::PP_IDLE;
            tick_in_phase = '0;
            fin = 1'b1;
        end
        s.step_accel = a_now[tmp_pkg::ACC_W-1:0];
        s.velocity = cur_velocity[tmp_pkg::VEL_W-1:0];
        s.position = cur_position[tmp_pkg::POS_W-1:0];
        s.phase = (cur == tmp_pkg::PP_ACCEL) ? tmp_pkg::OUT_ACCEL :
                  ((cur == tmp_pkg::PP_CRUISE) ? tmp_pkg::OUT_CRUISE : tmp_pkg::OUT_DECEL);
        s.last = fin;
        expected_samples.push_back(s);
    endtask

    // Offers one word and returns once the block has taken it. It is entered
    // and left at a falling edge; push stays high for a word that follows at once.
    task automatic send_word(input logic act, input logic [31:0] move_len,
                             input logic [31:0] spd, input logic [31:0] acc);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            push = 1'b0;
            action = $urandom_range(0, 1);
            @(negedge clk);
        end
        push = 1'b1;
        action = act;
        distance = move_len;
        speed_limit = spd;
        accel_limit = acc;
        do
            @(posedge clk);
        while (full);
        predict_profile(act, move_len, spd, acc);
        words_sent++;
        @(negedge clk);
    endtask

    // Ticks carry random payload, which the block must ignore.
    task automatic send_tick();
        send_word(1'b1, $urandom, $urandom, $urandom);
    endtask

    // Starts a move and ticks it to its end, with stray starts and idle ticks.
    task automatic run_move(input logic [31:0] move_len, input logic [31:0] spd,
                            input logic [31:0] acc);
        send_word(1'b0, move_len, spd, acc);
        while (run_state != tmp_pkg::PP_IDLE)
        begin
            if ($urandom_range(0, 99) < 4)
                send_word(1'b0, $urandom, $urandom, $urandom);
            send_tick();
        end
        if ($urandom_range(0, 99) < 10)
            send_tick();
    endtask

    // Draws a move whose length stays within MOVE_TICKS_MAX ticks.
    task automatic random_move();
        logic [63:0] a;
        logic [63:0] mag;
        logic [63:0] v;
        logic [31:0] move_len;
        move_plan_t  p;
        int          t;
        for (int tries = 0; tries < 20; tries++)
        begin
            a = {32'd0, $urandom} >> $urandom_range(0, 31);
            if (a == 0)
                a = 1;
            t = $urandom_range(1, 24);
            mag = ((a * t * t) >> 16) + $urandom_range(0, 3);
            if (mag == 0)
                mag = 1;
            if (mag > 64'h7FFF_FFFF)
                mag = 64'h7FFF_FFFF;
            case ($urandom_range(0, 2))
                0: v = {32'd0, $urandom};
                1: v = a * $urandom_range(1, t) + $urandom_range(0, 255);
                default: v = {32'd0, $urandom} >> $urandom_range(0, 31);
            endcase
            if (v > MASK32)
                v = MASK32;
            if (v == 0)
                v = 1;
            move_len = $urandom_range(0, 1) ? -mag[31:0] : mag[31:0];
            p = plan_move(move_len, v[31:0], a[31:0]);
            if (p.ok && 2 * p.ramp_ticks + p.cruise_ticks <= MOVE_TICKS_MAX)
            begin
                run_move(move_len, v[31:0], a[31:0]);
                return;
            end
        end
        // Nothing short enough came up: a four-tick move.
        run_move(32'd4, 32'hFFFF_FFFF, 32'h0001_0000);
    endtask

    // Random traffic: mostly whole moves, a few starts with a zero field and
    // stray ticks while idle.
    task automatic run_random(input int n_words);
        int stop_at;
        stop_at = words_sent + n_words;
        while (words_sent < stop_at)
        begin
            case ($urandom_range(0, 19))
                0: send_word(1'b0, 32'd0, $urandom, $urandom);
                1: send_word(1'b0, $urandom, $urandom, 32'd0);
                2: send_word(1'b0, $urandom, 32'd0, $urandom);
                3: send_tick();
                default: random_move();
            endcase
        end
    endtask

    task automatic test_directed();
        send_idle_pct = 0;
        pop_stall_pct = 0;
        // Ticks with no move running give nothing.
        send_tick();
        // Starts with a zero distance, speed or acceleration are dropped.
        send_word(1'b0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(1'b0, 32'd100, 32'd0, 32'h0001_0000);
        send_word(1'b0, 32'd100, 32'h0001_0000, 32'd0);
        send_tick();
        // One-tick ramp: the whole distance in a single acceleration step.
        run_move(32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // Speed limit reached: accelerate, cruise, decelerate.
        send_word(1'b0, 32'd100, 32'h0002_0000, 32'h0001_0000);
        send_tick();
        // A start in the middle of a move is dropped, even the most negative one.
        send_word(1'b0, -32'sd5, 32'd1, 32'd1);
        send_word(1'b0, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        while (run_state != tmp_pkg::PP_IDLE)
            send_tick();
        // Ramp time equal to the speed limit time: no cruise.
        run_move(-32'sd4, 32'h0002_0000, 32'h0001_0000);
        // Large distances of both signs with the largest limits: a one-tick
        // ramp into a cruise near the top of the velocity range.
        run_move(32'hFFF0_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        run_move(32'h0010_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    endtask

    task automatic test_streaming();
        send_idle_pct = 0;
        pop_stall_pct = 0;
        run_random(320);
    endtask

    task automatic test_sender_gaps();
        send_idle_pct = 84;
        pop_stall_pct = 0;
        run_random(280);
    endtask

    task automatic test_receiver_stalls();
        send_idle_pct = 0;
        pop_stall_pct = 84;
        run_random(280);
    endtask

    task automatic test_both_idle();
        send_idle_pct = 24;
        pop_stall_pct = 24;
        run_random(320);
    endtask

    // The receiver holds off while an 80-tick move is fed without gaps, so the
    // result queue fills and the block must raise full and keep every word.
    // The hold-off outlasts the planning of the start by a long stretch.
    task automatic test_backpressure();
        send_idle_pct = 0;
        pop_stall_pct = 0;
        send_word(1'b0, 32'd1600, 32'hFFFF_FFFF, 32'h0001_0000);
        pop_hold_cycles = START_CYCLES + 150;
        while (run_state != tmp_pkg::PP_IDLE)
            send_tick();
    endtask

    // Pop is changed at the falling edge; a hold-off counts down in cycles.
    always @(negedge clk)
    begin
        if (pop_hold_cycles > 0)
        begin
            pop = 1'b0;
            pop_hold_cycles = pop_hold_cycles - 1;
        end
        else
            pop = ($urandom_range(0, 99) >= pop_stall_pct);
    end

    // Every word taken from the block is checked against the oldest expected sample.
    always @(posedge clk)
    begin
        tmp_pkg::res_t want;
        if (rst_n && pop && !empty)
        begin
            if (expected_samples.size() == 0)
            begin
                $display("%0t: unexpected word: accel %0d velocity %0d position %0d",
                         $time, step_accel, velocity, position);
                $display("%0t: unexpected word: phase %0d last %0d", $time, phase, last);
                err_cnt++;
            end
            else
            begin
                want = expected_samples.pop_front();
                if (step_accel !== want.step_accel)
                begin
                    $display("%0t: step_accel expected %0d actual %0d",
                             $time, want.step_accel, step_accel);
                    err_cnt++;
                end
                if (velocity !== want.velocity)
                begin
                    $display("%0t: velocity expected %0d actual %0d",
                             $time, want.velocity, velocity);
                    err_cnt++;
                end
                if (position !== want.position)
                begin
                    $display("%0t: position expected %0d actual %0d",
                             $time, want.position, position);
                    err_cnt++;
                end
                if (phase !== want.phase)
                begin
                    $display("%0t: phase expected %0d actual %0d", $time, want.phase, phase);
                    err_cnt++;
                end
                if (last !== want.last)
                begin
                    $display("%0t: last expected %0d actual %0d", $time, want.last, last);
                    err_cnt++;
                end
            end
        end
    end

    // Generous limit: far beyond the slowest correct run.
    initial
    begin
        #24_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_streaming();
        test_sender_gaps();
        test_receiver_stalls();
        test_both_idle();
        test_backpressure();

        push = 1'b0;
        send_idle_pct = 0;
        pop_stall_pct = 0;
        // Drain what is owed, then give a trailing start time to finish.
        while (expected_samples.size() != 0)
            @(negedge clk);
        repeat (START_CYCLES) @(negedge clk);

        if (err_cnt == 0 && expected_samples.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== files.f =====
sv/tmp_pkg.sv
sv/tmp_front.sv
sv/tmp_div.sv
sv/tmp_sqrt.sv
sv/tmp_back.sv
sv/trapezoid_motion_profile.sv
sim/tb_trapezoid_motion_profile.sv
